// File: rtl/mbss_pkg.sv
// ----------------------------------------------------------------------------
// mbss_pkg
// shared types and constants of the masked byte signature scan unit
// ----------------------------------------------------------------------------
package mbss_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_W       = 5;
	localparam int OFFSET_W    = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;
	localparam int PAT_BYTES   = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW  = 2'd0,
		CFG_PATTERN_HIGH = 2'd1,
		CFG_CARE_MASK    = 2'd2,
		CFG_PATTERN_LEN  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
	} out_item_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

endpackage

// File: rtl/mbss_front.sv
// ----------------------------------------------------------------------------
// mbss_front
// byte window, region offset counter and masked compare; emits result items
// ----------------------------------------------------------------------------
module mbss_front #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  mbss_pkg::in_item_t                    item,
	input  logic [mbss_pkg::LEN_W-1:0]            eff_len,
	input  logic [MAX_PATTERN-1:0][7:0]           aligned_pat,
	input  logic [MAX_PATTERN-1:0]                aligned_care,
	output logic                                  push,
	output mbss_pkg::out_item_t                   push_item
);

	logic [MAX_PATTERN-1:0][7:0] window_q;
	logic [MAX_PATTERN-1:0][7:0] window_next;
	logic [OFFSET_BITS-1:0]      seen_q;
	logic                        hit_q;
	logic [OFFSET_BITS-1:0]      taken;
	logic [OFFSET_BITS-1:0]      len_ext;
	logic [OFFSET_BITS-1:0]      diff;
	logic [OFFSET_BITS+31:0]     diff_ext;
	logic                        seen_open;
	logic                        match;
	logic                        hit_now;

	// newest byte in entry 0
	always_comb begin
		window_next[0] = item.data_byte;
		for (int a = 1; a < MAX_PATTERN; a++) begin
			window_next[a] = window_q[a-1];
		end
	end

	always_comb begin
		match = 1'b1;
		for (int a = 0; a < MAX_PATTERN; a++) begin
			if (aligned_care[a] && (window_next[a] != aligned_pat[a])) begin
				match = 1'b0;
			end
		end
	end

	assign seen_open = (seen_q != {OFFSET_BITS{1'b1}});
	assign taken     = seen_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	assign len_ext   = {{(OFFSET_BITS-mbss_pkg::LEN_W){1'b0}}, eff_len};
	assign diff      = taken - len_ext;
	assign diff_ext  = {32'd0, diff};
	assign hit_now   = !hit_q && seen_open && (eff_len != '0) && (taken >= len_ext) && match;

	always_comb begin
		push = 1'b0;
		push_item.found = 1'b0;
		push_item.match_offset = '0;
		if (accept && !hit_q) begin
			if (hit_now) begin
				push = 1'b1;
				push_item.found = 1'b1;
				push_item.match_offset = diff_ext[mbss_pkg::OFFSET_W-1:0];
			end else if (item.last_byte) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			hit_q    <= 1'b0;
		end else if (accept) begin
			if (!hit_q) begin
				window_q <= window_next;
			end
			// region end restarts the scan
			if (item.last_byte) begin
				seen_q <= '0;
				hit_q  <= 1'b0;
			end else if (!hit_q) begin
				if (seen_open) begin
					seen_q <= taken;
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/mbss_queue.sv
// ----------------------------------------------------------------------------
// mbss_queue
// short result queue between the compare front and the output stage
// ----------------------------------------------------------------------------
module mbss_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mbss_pkg::out_item_t     push_item,
	input  logic                    pop,
	output mbss_pkg::out_item_t     head,
	output mbss_pkg::queue_status_t status
);

	mbss_pkg::out_item_t                mem_q [mbss_pkg::QUEUE_DEPTH];
	logic [mbss_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [mbss_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [mbss_pkg::QUEUE_CNT_W-1:0]   count_q;

	assign head             = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.full      = (count_q == mbss_pkg::QUEUE_CNT_W'(mbss_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mbss_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mbss_pkg::QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mbss_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mbss_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/mbss_back.sv
// ----------------------------------------------------------------------------
// mbss_back
// output register that drains the result queue toward the consumer
// ----------------------------------------------------------------------------
module mbss_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbss_pkg::queue_status_t status,
	input  mbss_pkg::out_item_t     head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output mbss_pkg::out_item_t     out_item
);

	logic                out_valid_q;
	mbss_pkg::out_item_t out_item_q;

	assign pop       = status.not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= head;
		end
	end

endmodule

// File: rtl/masked_byte_signature_scan_unit.sv
// out_valid rises once the result of the causing input item has passed the result queue and the output register
// throughput: one byte item per cycle while in_stall is low, set by the combinational parallel window compare
// a four-entry result queue lets the input keep flowing while a result waits on out_stall
// reset (arst_n low): window, offset counter, queue and output valid clear,
// pattern registers clear, care mask goes to all ones, pattern length to one
// ----------------------------------------------------------------------------
// masked_byte_signature_scan_unit
// wildcard byte signature search over a byte stream, one result per region
// ----------------------------------------------------------------------------
module masked_byte_signature_scan_unit #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [mbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// byte items in
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mbss_pkg::in_item_t                  in_item,
	// result items out
	output logic                                out_valid,
	input  logic                                out_stall,
	output mbss_pkg::out_item_t                 out_item
);

	// configuration registers
	logic [mbss_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [mbss_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [mbss_pkg::PAT_BYTES-1:0]  care_q;
	logic [mbss_pkg::LEN_W-1:0]      len_q;

	logic [mbss_pkg::LEN_W-1:0]        eff_len;
	logic [2*mbss_pkg::CFG_DATA_W-1:0] pat_all;
	logic [MAX_PATTERN-1:0][7:0]       aligned_pat;
	logic [MAX_PATTERN-1:0]            aligned_care;

	logic                    accept;
	logic                    push;
	logic                    pop;
	mbss_pkg::out_item_t     push_item;
	mbss_pkg::out_item_t     head;
	mbss_pkg::queue_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			len_q      <= mbss_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			case (mbss_pkg::cfg_index_t'(cfg_index))
				mbss_pkg::CFG_PATTERN_LOW:  pat_low_q  <= cfg_wdata;
				mbss_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_wdata;
				mbss_pkg::CFG_CARE_MASK:    care_q     <= cfg_wdata[mbss_pkg::PAT_BYTES-1:0];
				mbss_pkg::CFG_PATTERN_LEN:  len_q      <= cfg_wdata[mbss_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// lengths above the window depth are clamped
	assign eff_len = (len_q > mbss_pkg::LEN_W'(MAX_PATTERN)) ? mbss_pkg::LEN_W'(MAX_PATTERN)
	                                                         : len_q;
	assign pat_all = {pat_high_q, pat_low_q};

	// line the pattern up with window age: entry a holds pattern byte len-1-a,
	// and ages at or past the length are don't-care
	always_comb begin
		logic [mbss_pkg::LEN_W-1:0] idx;
		for (int a = 0; a < MAX_PATTERN; a++) begin
			idx = eff_len - mbss_pkg::LEN_W'(a) - mbss_pkg::LEN_W'(1);
			aligned_pat[a]  = pat_all[idx[3:0]*8 +: 8];
			aligned_care[a] = (eff_len > mbss_pkg::LEN_W'(a)) && care_q[idx[3:0]];
		end
	end

	// front stalls only when the queue is full
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	mbss_front #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (in_item),
		.eff_len      (eff_len),
		.aligned_pat  (aligned_pat),
		.aligned_care (aligned_care),
		.push         (push),
		.push_item    (push_item)
	);

	mbss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	mbss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// File: rtl/mbss_checker.sv
// ----------------------------------------------------------------------------
// mbss_checker
// port-level checks of the scan unit, bound to the top level
// ----------------------------------------------------------------------------
module mbss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input mbss_pkg::out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// a not-found result carries offset zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.match_offset == '0)
		else $error("miss result with nonzero offset");

	// input backpressure only while a result sits in the output
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// the queue fills only while the consumer holds off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without output stall");

	// a stalled input item stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input item withdrawn while stalled");

endmodule

bind masked_byte_signature_scan_unit mbss_checker u_mbss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
